/* rtl/pixel_doubler_scanline_macros.svh */
// Assertion macros shared by the pixel doubler RTL.
`ifndef PIXEL_DOUBLER_SCANLINE_MACROS_SVH
`define PIXEL_DOUBLER_SCANLINE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PXD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PXD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/pxdbl_pkg.sv */
// Types and constants shared by the pixel doubler modules.
package pxdbl_pkg;

  typedef enum logic [1:0] {
    MODE_REPLICATE = 2'd0,
    MODE_SCANLINE  = 2'd1,
    MODE_GRID      = 2'd2,
    MODE_NARROW    = 2'd3
  } mode_t;

  localparam logic [1:0] REG_MODE         = 2'd0;
  localparam logic [1:0] REG_BLEND_WEIGHT = 2'd1;
  localparam logic [1:0] REG_DARK_COLOR   = 2'd2;

  localparam logic [15:0] HALF_MASK    = 16'h7BEF;
  localparam logic [15:0] QUARTER_MASK = 16'h39E7;
  localparam logic [15:0] LOW1_MASK    = 16'h0821;
  localparam logic [15:0] LOW2_MASK    = 16'h1863;

  // Reciprocal of three scaled by 2**11; exact for sums below 2048.
  localparam logic [20:0] RECIP3       = 21'd683;
  localparam int unsigned RECIP3_SHIFT = 11;

  localparam logic [1:0] PPR_DOUBLE = 2'd2;
  localparam logic [1:0] PPR_SINGLE = 2'd1;

endpackage

/* rtl/pxdbl_blend.sv */
// Darkening blend of one RGB565 pixel with the dark color.
module pxdbl_blend
  import pxdbl_pkg::*;
(
  input  logic [15:0] pixel,
  input  logic [15:0] dark,
  input  logic        weight,
  output logic [15:0] darkened
);

  logic [7:0]  ra, rb, ga, gb, ba, bb;
  logic [9:0]  r_sum, g_sum, b_sum;
  logic [20:0] r_prod, g_prod, b_prod;
  logic [7:0]  r_q, g_q, b_q;
  logic [15:0] two_one;

  logic [16:0] fix_sum;
  logic [15:0] fix, half_a, quarter_a, quarter_b, three_one;

  // Channels widened to 8 bits, then (2*src + dark) / 3 truncated.
  always_comb begin
    ra = {pixel[15:11], 3'b000};
    rb = {dark[15:11], 3'b000};
    ga = {pixel[10:5], 2'b00};
    gb = {dark[10:5], 2'b00};
    ba = {pixel[4:0], 3'b000};
    bb = {dark[4:0], 3'b000};
    r_sum = {2'b00, ra} + {2'b00, ra} + {2'b00, rb};
    g_sum = {2'b00, ga} + {2'b00, ga} + {2'b00, gb};
    b_sum = {2'b00, ba} + {2'b00, ba} + {2'b00, bb};
    r_prod = {11'd0, r_sum} * RECIP3;
    g_prod = {11'd0, g_sum} * RECIP3;
    b_prod = {11'd0, b_sum} * RECIP3;
    r_q = r_prod[RECIP3_SHIFT +: 8];
    g_q = g_prod[RECIP3_SHIFT +: 8];
    b_q = b_prod[RECIP3_SHIFT +: 8];
    two_one = {r_q[7:3], g_q[7:2], b_q[7:3]};
  end

  // Half plus two quarters, with the low bits that the shifts drop added back.
  always_comb begin
    fix_sum   = {(pixel & LOW1_MASK), 1'b0} + {1'b0, (pixel & LOW2_MASK)}
              + {1'b0, (dark & LOW2_MASK)};
    fix       = {1'b0, fix_sum[16:2]} & QUARTER_MASK;
    half_a    = {1'b0, pixel[15:1]} & HALF_MASK;
    quarter_a = {2'b00, pixel[15:2]} & QUARTER_MASK;
    quarter_b = {2'b00, dark[15:2]} & QUARTER_MASK;
    three_one = half_a + quarter_a + quarter_b + fix;
  end

  assign darkened = weight ? three_one : two_one;

endmodule

/* rtl/pixel_doubler_scanline.sv */
// Pipeline: a pixel beat accepted into the input register is passed on to the result
// register, which drives the result port until the beat is taken.
// Throughput: one pixel per cycle; the input register and the result register
// advance together and stall only when out_tready is low with both full.
// Reset: synchronous active-low rst_n clears both valid flags and restores
// mode to scanline, blend_weight to 0 and dark_color to black.
module pixel_doubler_scanline
  import pxdbl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] pixel
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [15:0] top_left, [31:16] top_right,
                                  // [47:32] bottom_left, [63:48] bottom_right,
                                  // [65:64] pixels_per_row, [71:66] zero
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  mode_t       mode_r;
  logic        blend_weight_r;
  logic [15:0] dark_color_r;
  logic        cfg_wr;
  logic [1:0]  cfg_index;

  logic        s1_valid_r;
  logic [15:0] s1_pixel_r;
  logic        s1_adv;
  logic        out_valid_r;
  logic [65:0] out_data_r;
  logic [65:0] result_nxt;
  logic [15:0] darkened;

  // Configuration registers.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_index  = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= MODE_SCANLINE;
      blend_weight_r <= 1'b0;
      dark_color_r   <= 16'h0000;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_MODE:         mode_r         <= mode_t'(cfg_pwdata[1:0]);
        REG_BLEND_WEIGHT: blend_weight_r <= cfg_pwdata[0];
        REG_DARK_COLOR:   dark_color_r   <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      REG_MODE:         cfg_prdata = {30'd0, mode_r};
      REG_BLEND_WEIGHT: cfg_prdata = {31'd0, blend_weight_r};
      REG_DARK_COLOR:   cfg_prdata = {16'd0, dark_color_r};
      default:          cfg_prdata = 32'd0;
    endcase
  end

  // Pipeline handshake: the result register frees up when its beat is taken.
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_pixel_r <= in_tdata;
    end
    if (s1_adv) begin
      out_data_r <= result_nxt;
    end
  end

  pxdbl_blend u_blend (
    .pixel    (s1_pixel_r),
    .dark     (dark_color_r),
    .weight   (blend_weight_r),
    .darkened (darkened)
  );

  // Field order from the low end: tl, tr, bl, br, pixels_per_row.
  always_comb begin
    unique case (mode_r)
      MODE_REPLICATE:
        result_nxt = {PPR_DOUBLE, s1_pixel_r, s1_pixel_r, s1_pixel_r, s1_pixel_r};
      MODE_SCANLINE:
        result_nxt = {PPR_DOUBLE, darkened, darkened, s1_pixel_r, s1_pixel_r};
      MODE_GRID:
        result_nxt = {PPR_DOUBLE, darkened, darkened, darkened, s1_pixel_r};
      MODE_NARROW:
        result_nxt = {PPR_SINGLE, 16'h0000, darkened, 16'h0000, s1_pixel_r};
      default:
        result_nxt = {PPR_DOUBLE, s1_pixel_r, s1_pixel_r, s1_pixel_r, s1_pixel_r};
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_data_r};

`include "pixel_doubler_scanline_macros.svh"

  `PXD_ASSERT_NOW(a_ppr_range, out_tvalid, (out_tdata[65:64] == PPR_SINGLE) || (out_tdata[65:64] == PPR_DOUBLE), "pixels_per_row out of range")
  `PXD_ASSERT_NOW(a_narrow_zero, out_tvalid && (out_tdata[65:64] == PPR_SINGLE), (out_tdata[31:16] == 16'h0000) && (out_tdata[63:48] == 16'h0000), "single width result has nonzero right pixels")
  `PXD_ASSERT_NEXT(a_s1_hold, s1_valid_r && !s1_adv, s1_valid_r && $stable(s1_pixel_r), "stalled input stage lost its pixel")
  `PXD_ASSERT_NOW(a_ready_when_empty, !s1_valid_r, in_tready, "empty input stage refuses a beat")

endmodule

/* bench/pixel_doubler_scanline_test.sv */
// Self-checking bench for the RGB565 pixel doubler: scoreboard, drivers and checks.
module pixel_doubler_scanline_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pxdbl_pkg::*;

  localparam logic [3:0] ADDR_MODE  = {REG_MODE, 2'b00};
  localparam logic [3:0] ADDR_BLEND = {REG_BLEND_WEIGHT, 2'b00};
  localparam logic [3:0] ADDR_DARK  = {REG_DARK_COLOR, 2'b00};
  // One word past the register list; writes there must change nothing.
  localparam logic [3:0] ADDR_SPARE = 4'd12;
  localparam int unsigned STALL_LIMIT = 5000;

  typedef struct packed {
    logic [5:0]  pad;
    logic [1:0]  per_row;
    logic [15:0] bot_right;
    logic [15:0] bot_left;
    logic [15:0] top_right;
    logic [15:0] top_left;
  } pixel_block_t;

  class upscale_scoreboard;
    mode_t         mode;
    logic          blend;
    logic [15:0]   dark;
    pixel_block_t  pending[$];
    int unsigned   errors;
    int unsigned   checked;

    function new();
      mode    = MODE_SCANLINE;
      blend   = 1'b0;
      dark    = 16'h0000;
      errors  = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [3:0] addr, logic [31:0] data);
      case (addr)
        ADDR_MODE:  mode  = mode_t'(data[1:0]);
        ADDR_BLEND: blend = data[0];
        ADDR_DARK:  dark  = data[15:0];
        default: ;
      endcase
    endfunction

    function void check_readback(logic [3:0] addr, logic [31:0] data);
      logic [31:0] want;
      case (addr)
        ADDR_MODE:  want = {30'b0, mode};
        ADDR_BLEND: want = {31'b0, blend};
        default:    want = {16'b0, dark};
      endcase
      if (data !== want) begin
        $display("%0t: register at 0x%0h reads 0x%0h, expected 0x%0h", $time, addr, data, want);
        errors++;
      end
    endfunction

    // Two parts source to one part dark, per channel at 8 bits, truncated.
    function logic [15:0] mix_two_one(logic [15:0] a, logic [15:0] b);
      int unsigned ra, rb, ga, gb, ba, bb, r, g, bl;
      ra = {a[15:11], 3'b000};
      rb = {b[15:11], 3'b000};
      ga = {a[10:5], 2'b00};
      gb = {b[10:5], 2'b00};
      ba = {a[4:0], 3'b000};
      bb = {b[4:0], 3'b000};
      r  = ((ra + ra + rb) / 3) & 32'hf8;
      g  = ((ga + ga + gb) / 3) & 32'hfc;
      bl = ((ba + ba + bb) / 3) & 32'hf8;
      return {r[7:3], g[7:2], bl[7:3]};
    endfunction

    // Half plus quarter of the source and a quarter of dark; the low bits that
    // the masked shifts drop are summed separately and added back.
    function logic [15:0] mix_three_one(logic [15:0] a, logic [15:0] b);
      int unsigned av, bv, lost, sum;
      av   = a;
      bv   = b;
      lost = ((av & LOW1_MASK) << 1) + (av & LOW2_MASK) + (bv & LOW2_MASK);
      lost = (lost >> 2) & QUARTER_MASK;
      sum  = ((av >> 1) & HALF_MASK) + ((av >> 2) & QUARTER_MASK)
           + ((bv >> 2) & QUARTER_MASK) + lost;
      return sum[15:0];
    endfunction

    function void note_pixel(logic [15:0] px);
      pixel_block_t blk;
      logic [15:0]  dim;
      dim = blend ? mix_three_one(px, dark) : mix_two_one(px, dark);
      blk = '{pad: 6'b0, per_row: PPR_DOUBLE, bot_right: px, bot_left: px,
              top_right: px, top_left: px};
      case (mode)
        MODE_REPLICATE: ;
        MODE_SCANLINE: begin
          blk.bot_left  = dim;
          blk.bot_right = dim;
        end
        MODE_GRID: begin
          blk.top_right = dim;
          blk.bot_left  = dim;
          blk.bot_right = dim;
        end
        default: begin
          blk.top_right = 16'h0000;
          blk.bot_left  = dim;
          blk.bot_right = 16'h0000;
          blk.per_row   = PPR_SINGLE;
        end
      endcase
      pending.push_back(blk);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected 0x%04h, got 0x%04h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_block(logic [71:0] data);
      pixel_block_t got, want;
      got = data;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat 0x%018h", $time, data);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      compare_field("top_left", want.top_left, got.top_left);
      compare_field("top_right", want.top_right, got.top_right);
      compare_field("bottom_left", want.bot_left, got.bot_left);
      compare_field("bottom_right", want.bot_right, got.bot_right);
      compare_field("pixels_per_row", {14'b0, want.per_row}, {14'b0, got.per_row});
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;    // [15:0] pixel
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;   // [15:0] top_left, [31:16] top_right, [47:32] bottom_left,
                            // [63:48] bottom_right, [65:64] pixels_per_row
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  upscale_scoreboard sb = new();

  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned idle_cycles;
  int unsigned beats_sent;
  int unsigned settings_used;
  int unsigned ready_style;
  int unsigned style_left;
  int unsigned stall_count;

  pixel_doubler_scanline i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #1 clk = ~clk;

  // The receiver switches between several stall patterns, including stretches
  // where it never stalls.
  always @(negedge clk) begin
    if (style_left == 0) begin
      ready_style <= $urandom_range(0, 3);
      style_left  <= $urandom_range(16, 96);
    end else begin
      style_left <= style_left - 1;
    end
    stall_count <= stall_count + 1;
    case (ready_style)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= stall_count[3];
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_pixel(in_tdata);
      if (out_tvalid && out_tready) sb.check_block(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("Verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_pixel(input logic [15:0] px);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
    end
    while (gap_left > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      in_tdata  <= 16'($urandom);
      @(posedge clk);
      gap_left--;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    beats_sent++;
  endtask

  task automatic drain;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.write_reg(addr, data);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic apb_read_check(input logic [3:0] addr);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= addr;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.check_readback(addr, cfg_prdata);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Unused upper bits of each write carry random junk that must be dropped.
  task automatic apply_setting(input mode_t md, input logic bw, input logic [15:0] dk);
    logic [31:0] word;
    word = $urandom;
    word[1:0] = md;
    apb_write(ADDR_MODE, word);
    word = $urandom;
    word[0] = bw;
    apb_write(ADDR_BLEND, word);
    word = $urandom;
    word[15:0] = dk;
    apb_write(ADDR_DARK, word);
    if ($urandom_range(0, 2) == 0) apb_write(ADDR_SPARE, $urandom);
    apb_read_check(ADDR_MODE);
    apb_read_check(ADDR_BLEND);
    apb_read_check(ADDR_DARK);
    settings_used++;
  endtask

  function automatic logic [15:0] random_pixel();
    logic [15:0] px;
    px = 16'($urandom);
    // A quarter of the pixels have every channel at zero or full scale.
    if ($urandom_range(0, 3) == 0) begin
      px[15:11] = {5{px[15]}};
      px[10:5]  = {6{px[10]}};
      px[4:0]   = {5{px[4]}};
    end
    return px;
  endfunction

  initial begin
    logic [15:0] corner_pixels[6];
    mode_t       md;
    logic [15:0] dk;
    int unsigned count;

    clk         = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = 16'h0000;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = 4'h0;
    cfg_pwdata  = 32'h0;
    burst_left  = 0;
    gap_left    = 0;
    idle_cycles = 0;
    beats_sent  = 0;
    settings_used = 1;
    ready_style = 0;
    style_left  = 0;
    stall_count = 0;
    corner_pixels = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07E0, 16'h001F, 16'h0821};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Corner pixels under the reset setting first, then one setting per remaining mode.
    apb_read_check(ADDR_MODE);
    apb_read_check(ADDR_BLEND);
    apb_read_check(ADDR_DARK);
    foreach (corner_pixels[i]) send_pixel(corner_pixels[i]);
    drain();
    apply_setting(MODE_REPLICATE, 1'b1, 16'hFFFF);
    foreach (corner_pixels[i]) send_pixel(corner_pixels[i]);
    drain();
    apply_setting(MODE_GRID, 1'b0, 16'h1863);
    foreach (corner_pixels[i]) send_pixel(corner_pixels[i]);
    drain();
    apply_setting(MODE_NARROW, 1'b1, 16'h0000);
    foreach (corner_pixels[i]) send_pixel(corner_pixels[i]);
    drain();

    count = 0;
    while (count < 500) begin
      md = mode_t'($urandom_range(0, 3));
      case ($urandom_range(0, 3))
        0:       dk = 16'h0000;
        1:       dk = 16'hFFFF;
        default: dk = 16'($urandom);
      endcase
      apply_setting(md, 1'($urandom_range(0, 1)), dk);
      repeat ($urandom_range(20, 70)) begin
        send_pixel(random_pixel());
        count++;
      end
      drain();
    end

    repeat (6) @(posedge clk);
    $display("Sent %0d pixel beats and checked %0d result beats over %0d register settings,",
             beats_sent, sb.checked, settings_used);
    $display("with all four modes, both blend weights and dark colors from black to white.");
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
